>>> rtl/core/lrsa_pkg.sv
// Shared types, constants and helper functions for the LED ring slide animation.
// No dependencies; every other file of the block but lrsa_if imports this package.
`timescale 1ns / 1ps

package lrsa_pkg;

  localparam int LED_COUNT  = 64;
  localparam int EDGE_WIDTH = 4;
  localparam int IDX_W      = $clog2(LED_COUNT);
  localparam int DIST_W     = $clog2(LED_COUNT + 1);

  localparam logic [7:0] FADE_FULL        = 8'd255;
  localparam logic [6:0] MAX_RADIUS_RESET = 7'd36;

  typedef enum logic [1:0] {
    OP_START_ON  = 2'd0,
    OP_START_OFF = 2'd1,
    OP_REVERSE   = 2'd2,
    OP_FRAME     = 2'd3
  } op_t;

  // Frame context latched when a frame step is accepted
  typedef struct packed {
    logic [IDX_W-1:0]  center;
    logic signed [7:0] radius;
    logic              dark;
    logic              running;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        white;
  } frame_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
  } pix_t;

  // Sequencer to datapath/output stage
  typedef struct packed {
    logic             emit;
    logic [IDX_W-1:0] idx;
    logic             last;
  } seq_t;

  // Centre position folded onto the ring (small constant table)
  function automatic logic [IDX_W-1:0] center_wrap(logic [5:0] v);
    logic [IDX_W-1:0] res;
    res = '0;
    for (int k = 0; k < 64; k++) begin
      if (v == 6'(k)) res = IDX_W'(k % LED_COUNT);
    end
    return res;
  endfunction

  // Fade level inside the edge band, step counted from the outer rim
  function automatic logic [7:0] edge_fade(logic [4:0] step);
    logic [7:0] res;
    res = '0;
    for (int k = 0; k < EDGE_WIDTH; k++) begin
      if (step == 5'(k)) res = 8'((k * 255) / EDGE_WIDTH);
    end
    return res;
  endfunction

  // ch * fade / 255, truncated; reciprocal form exact over the 16-bit product
  function automatic logic [7:0] scale_channel(logic [7:0] ch, logic [7:0] fade);
    logic [15:0] prod;
    logic [16:0] q;
    logic [16:0] s;
    prod = ch * fade;
    q    = {1'b0, prod} + 17'd1;
    s    = q + (q >> 8);
    return s[15:8];
  endfunction

endpackage

>>> rtl/core/lrsa_if.sv
// Valid/ready channel interfaces for command words in and LED colour words out.
// No dependencies; the widths are given as literals.
`timescale 1ns / 1ps

interface lrsa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [5:0] center_led;
  logic [7:0] base_red;
  logic [7:0] base_green;
  logic [7:0] base_blue;
  logic [7:0] base_white;

  modport source (output valid, opcode, center_led, base_red, base_green, base_blue,
                  base_white, input ready);
  modport sink   (input valid, opcode, center_led, base_red, base_green, base_blue,
                  base_white, output ready);
endinterface

interface lrsa_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] led_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_white;
  logic       last_led;
  logic       still_running;

  modport source (output valid, led_index, out_red, out_green, out_blue, out_white,
                  last_led, still_running, input ready);
  modport sink   (input valid, led_index, out_red, out_green, out_blue, out_white,
                  last_led, still_running, output ready);
endinterface

>>> rtl/core/lrsa_pixel_unit.sv
// Shared per-LED unit: ring distance, fade level and four channel scalers.
// Depends on lrsa_pkg.
`timescale 1ns / 1ps

module lrsa_pixel_unit (
  input  lrsa_pkg::frame_t             frame,
  input  logic [lrsa_pkg::IDX_W-1:0]   idx,
  output lrsa_pkg::pix_t               pix
);
  import lrsa_pkg::*;

  logic [DIST_W-1:0] fwd;
  logic [DIST_W-1:0] bwd;
  logic [DIST_W-1:0] ring_dist;
  logic signed [8:0] diff;
  logic [7:0]        fade;

  always_comb begin
    if (idx >= frame.center) begin
      fwd = DIST_W'(idx) - DIST_W'(frame.center);
    end else begin
      fwd = DIST_W'(idx) + DIST_W'(LED_COUNT) - DIST_W'(frame.center);
    end
    bwd       = DIST_W'(LED_COUNT) - fwd;
    ring_dist = (fwd < bwd) ? fwd : bwd;
  end

  // radius - distance, signed; negative means outside the disc
  assign diff = $signed({frame.radius[7], frame.radius}) - $signed(9'(ring_dist));

  always_comb begin
    if (frame.dark || diff < 0) begin
      fade = '0;
    end else if (diff >= $signed(9'(EDGE_WIDTH))) begin
      fade = FADE_FULL;
    end else begin
      fade = edge_fade(diff[4:0]);
    end
  end

  assign pix.red   = scale_channel(frame.red,   fade);
  assign pix.green = scale_channel(frame.green, fade);
  assign pix.blue  = scale_channel(frame.blue,  fade);
  assign pix.white = scale_channel(frame.white, fade);

endmodule

>>> rtl/core/lrsa_ctrl.sv
// Animation state, max_radius register and the LED sequencer of a frame step.
// Depends on lrsa_pkg and lrsa_in_if.
`timescale 1ns / 1ps

module lrsa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  lrsa_in_if.sink              item_in,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_data,
  input  logic                 out_free,
  output lrsa_pkg::frame_t     frame,
  output lrsa_pkg::seq_t       seq
);
  import lrsa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_RENDER = 2'b10
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  idx;
  logic [6:0]        max_radius;
  logic [IDX_W-1:0]  center;
  logic signed [7:0] radius;
  logic              growing;

  logic              accept;
  op_t               op;
  logic signed [7:0] radius_next;
  logic signed [8:0] maxr9;
  logic              finished;
  logic              last;

  assign item_in.ready = (state == ST_IDLE);
  assign accept        = item_in.valid && item_in.ready;
  assign op            = op_t'(item_in.opcode);
  assign maxr9         = $signed({2'b00, max_radius});

  // saturating step of the radius
  always_comb begin
    if (growing) begin
      radius_next = (radius != 8'sd127) ? radius + 8'sd1 : radius;
    end else begin
      radius_next = (radius != -8'sd128) ? radius - 8'sd1 : radius;
    end
  end

  assign finished = growing ? ($signed({radius_next[7], radius_next}) >= maxr9)
                            : (radius_next < 0);

  assign last     = (idx == IDX_W'(LED_COUNT - 1));
  assign seq.emit = (state == ST_RENDER) && out_free;
  assign seq.idx  = idx;
  assign seq.last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_radius <= MAX_RADIUS_RESET;
    end else if (cfg_we) begin
      max_radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      idx     <= '0;
      center  <= '0;
      radius  <= '0;
      growing <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_START_ON: begin
                center  <= center_wrap(item_in.center_led);
                radius  <= '0;
                growing <= 1'b1;
              end
              OP_START_OFF: begin
                growing <= 1'b0;
                if ($signed({radius[7], radius}) >= maxr9 || radius < 0) begin
                  radius <= $signed({1'b0, max_radius});
                end
              end
              OP_REVERSE: begin
                growing <= 1'b1;
              end
              OP_FRAME: begin
                radius <= radius_next;
                idx    <= '0;
                state  <= ST_RENDER;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RENDER: begin
          if (seq.emit) begin
            if (last) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // frame context, held for the whole render pass
  always_ff @(posedge clk) begin
    if (accept && op == OP_FRAME) begin
      frame.center  <= center;
      frame.radius  <= radius;
      frame.dark    <= finished && !growing;
      frame.running <= !finished;
      frame.red     <= item_in.base_red;
      frame.green   <= item_in.base_green;
      frame.blue    <= item_in.base_blue;
      frame.white   <= item_in.base_white;
    end
  end

  a_frame_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_FRAME) |=> (state == ST_RENDER && idx == '0))
    else $error("frame step did not start render at LED 0");

  a_frame_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RENDER) |=> $stable(frame) && $stable(radius))
    else $error("frame context changed during render");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (seq.emit && seq.last) |=> (state == ST_IDLE))
    else $error("render did not end after last LED");

  a_idx_steps: assert property (@(posedge clk) disable iff (rst)
    (seq.emit && !seq.last) |=> (idx == $past(idx) + 1'b1))
    else $error("LED counter skipped");

endmodule

>>> rtl/core/led_ring_slide_animation_top.sv
// Top level of the LED ring slide animation: sequencer, shared pixel unit and
// output word register. Depends on lrsa_pkg, lrsa_if, lrsa_ctrl, lrsa_pixel_unit.
`timescale 1ns / 1ps

// Commands (start on, start off, reverse) are taken while the block is idle and
// produce no output. A frame step, once accepted, yields one colour word per
// LED, in LED order, from a single pixel unit stepped by the LED counter; the
// pass is held up only while the output side stalls. The input is not ready
// during that pass. The output register lets the last word of a frame wait
// while the next command is taken. max_radius may be written whenever the
// block is idle.
module led_ring_slide_animation_top (
  input  logic       clk,
  input  logic       rst,
  lrsa_in_if.sink    item_in,
  lrsa_out_if.source result_out,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data
);
  import lrsa_pkg::*;

  frame_t frame;
  seq_t   seq;
  pix_t   pix;
  logic   out_free;
  logic   out_valid;

  assign out_free = !out_valid || result_out.ready;

  lrsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .item_in  (item_in),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_free (out_free),
    .frame    (frame),
    .seq      (seq)
  );

  lrsa_pixel_unit u_pixel (
    .frame (frame),
    .idx   (seq.idx),
    .pix   (pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq.emit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.emit) begin
      result_out.led_index     <= 6'(seq.idx);
      result_out.out_red       <= pix.red;
      result_out.out_green     <= pix.green;
      result_out.out_blue      <= pix.blue;
      result_out.out_white     <= pix.white;
      result_out.last_led      <= seq.last;
      result_out.still_running <= frame.running;
    end
  end

  assign result_out.valid = out_valid;

endmodule

>>> dv/lrsa_frame_checker.sv
`timescale 1ns / 1ps
// Checker for the LED ring slide animation: tracks ring state and max_radius, predicts
// the colour words of every frame step and checks the output channel in order.
// Depends on lrsa_pkg and the lrsa_if channel interfaces.

module lrsa_frame_checker (
  input  logic       clk,
  input  logic       rst,
  lrsa_in_if         cmd_mon,
  lrsa_out_if        word_mon,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  output int         fail_count,
  output int         words_pending
);
  import lrsa_pkg::*;

  typedef struct packed {
    logic [5:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic       last;
    logic       running;
  } led_word_t;

  led_word_t         led_word_q[$];
  logic [5:0]        ring_centre;
  logic signed [7:0] ring_radius;
  logic              ring_growing;
  logic [6:0]        max_radius;

  function automatic logic [7:0] faded(logic [7:0] ch, int fade);
    return 8'((int'(ch) * fade) / 255);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // One frame step: render at the current radius, then move the radius on
  task automatic render_frame(input logic [7:0] r_in, input logic [7:0] g_in,
                              input logic [7:0] b_in, input logic [7:0] w_in);
    int        r;
    int        nr;
    int        dd;
    int        d;
    int        fade;
    int        c;
    bit        finished;
    bit        dark;
    led_word_t w;
    r = int'(ring_radius);
    if (ring_growing) nr = (r < 127) ? r + 1 : 127;
    else nr = (r > -128) ? r - 1 : -128;
    ring_radius = 8'(nr);
    finished = ring_growing ? (nr >= int'(max_radius)) : (nr < 0);
    dark = finished && !ring_growing;
    c = int'(ring_centre) % LED_COUNT;
    for (int i = 0; i < LED_COUNT; i++) begin
      dd = (i + LED_COUNT - c) % LED_COUNT;
      d = (dd < LED_COUNT - dd) ? dd : LED_COUNT - dd;
      fade = 0;
      if (!dark && d <= r)
        fade = (d <= r - EDGE_WIDTH) ? 255 : ((r - d) * 255) / EDGE_WIDTH;
      w.idx     = 6'(i);
      w.red     = faded(r_in, fade);
      w.green   = faded(g_in, fade);
      w.blue    = faded(b_in, fade);
      w.white   = faded(w_in, fade);
      w.last    = (i == LED_COUNT - 1);
      w.running = !finished;
      led_word_q.push_back(w);
    end
  endtask

  always @(posedge clk) begin : track
    led_word_t want;
    if (rst) begin
      led_word_q.delete();
      ring_centre  = '0;
      ring_radius  = '0;
      ring_growing = 1'b0;
      max_radius   = MAX_RADIUS_RESET;
      fail_count   = 0;
    end else begin
      // output side first: a word leaving now never belongs to a command taken now
      if (word_mon.valid && word_mon.ready) begin
        if (led_word_q.size() == 0) begin
          $error("unexpected word: led_index %0d", word_mon.led_index);
          fail_count++;
        end else begin
          want = led_word_q.pop_front();
          check_field("led_index", want.idx, word_mon.led_index);
          check_field("out_red", want.red, word_mon.out_red);
          check_field("out_green", want.green, word_mon.out_green);
          check_field("out_blue", want.blue, word_mon.out_blue);
          check_field("out_white", want.white, word_mon.out_white);
          check_field("last_led", want.last, word_mon.last_led);
          check_field("still_running", want.running, word_mon.still_running);
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        case (op_t'(cmd_mon.opcode))
          OP_START_ON: begin
            ring_centre  = cmd_mon.center_led;
            ring_radius  = '0;
            ring_growing = 1'b1;
          end
          OP_START_OFF: begin
            ring_growing = 1'b0;
            if (int'(ring_radius) >= int'(max_radius) || ring_radius < 0)
              ring_radius = 8'(max_radius);
          end
          OP_REVERSE: begin
            ring_growing = 1'b1;
          end
          OP_FRAME: begin
            render_frame(cmd_mon.base_red, cmd_mon.base_green, cmd_mon.base_blue,
                         cmd_mon.base_white);
          end
          default: begin
          end
        endcase
      end
      if (cfg_we) max_radius = cfg_data;
    end
    words_pending = led_word_q.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the LED ring slide animation: clock, reset, command stimulus,
// output back-pressure and verdict. Depends on lrsa_pkg, lrsa_if and lrsa_frame_checker.

module tb_top;
  import lrsa_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;

  int fail_count;
  int words_pending;
  bit hold_pending = 1'b0;
  int burst_left = 0;
  int ring_max = 36;

  lrsa_in_if  item_in ();
  lrsa_out_if result_out ();

  always #5 clk = ~clk;

  led_ring_slide_animation_top u_top (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .result_out (result_out),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  lrsa_frame_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd_mon       (item_in),
    .word_mon      (result_out),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  function automatic logic [31:0] rand_colour();
    logic [31:0] c;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 5))
        0: c[k*8 +: 8] = 8'h00;
        1: c[k*8 +: 8] = 8'hff;
        default: c[k*8 +: 8] = 8'($urandom);
      endcase
    end
    return c;
  endfunction

  // Offer one word; bursts of random length, random gaps between them
  task automatic send_word(input op_t op, input logic [5:0] ctr, input logic [31:0] colour);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        item_in.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    item_in.valid      = 1'b1;
    item_in.opcode     = op;
    item_in.center_led = ctr;
    item_in.base_red   = colour[31:24];
    item_in.base_green = colour[23:16];
    item_in.base_blue  = colour[15:8];
    item_in.base_white = colour[7:0];
    do @(posedge clk); while (!item_in.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_in.valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    // last word may still sit in the output register
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_radius(input int v);
    wait_drained();
    cfg_we   = 1'b1;
    cfg_data = 7'(v);
    ring_max = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_frames(input int n);
    repeat (n) send_word(OP_FRAME, 6'($urandom), rand_colour());
  endtask

  // Mostly command-plus-frames sequences, some single random words as noise
  task automatic run_sequences(input int n);
    int sent;
    int kind;
    int frames;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        send_word(op_t'(2'($urandom_range(0, 3))), 6'($urandom), rand_colour());
        sent++;
      end else begin
        if (kind <= 5) send_word(OP_START_ON, 6'($urandom), rand_colour());
        else if (kind <= 7) send_word(OP_START_OFF, 6'($urandom), rand_colour());
        else send_word(OP_REVERSE, 6'($urandom), rand_colour());
        frames = $urandom_range(1, ring_max + 6);
        if (frames > n - sent - 1) frames = n - sent - 1;
        send_frames(frames);
        sent += frames + 1;
      end
    end
  endtask

  // Receiver: own stall pattern, plus one long hold on request
  initial begin : receiver
    int mode;
    int span;
    result_out.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 80);
      repeat (span) begin
        @(negedge clk);
        if (hold_pending) begin
          result_out.ready = 1'b0;
          repeat (400) @(negedge clk);
          hold_pending = 1'b0;
        end
        case (mode)
          0: result_out.ready = 1'b1;
          1: result_out.ready = 1'($urandom_range(0, 1));
          2: result_out.ready = ($urandom_range(0, 3) == 0);
          default: result_out.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [31:0] palette [4];
    palette[0] = 32'hffff_ffff;
    palette[1] = 32'h0000_0000;
    palette[2] = 32'ha55a_a55a;
    palette[3] = 32'h5aa5_5aa5;
    item_in.valid      = 1'b0;
    item_in.opcode     = OP_START_ON;
    item_in.center_led = '0;
    item_in.base_red   = '0;
    item_in.base_green = '0;
    item_in.base_blue  = '0;
    item_in.base_white = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // frame straight after reset: finished slide-out, all dark
    send_word(OP_FRAME, 6'd0, palette[0]);
    // radius now below zero, so start off reloads max_radius
    send_word(OP_START_OFF, 6'd0, palette[1]);
    send_word(OP_FRAME, 6'd0, palette[0]);
    // centre at the ring end, growth through the edge band
    send_word(OP_START_ON, 6'd63, palette[2]);
    for (int k = 0; k < 6; k++) send_word(OP_FRAME, 6'd0, palette[k % 4]);
    send_word(OP_START_OFF, 6'd63, palette[3]);
    send_word(OP_FRAME, 6'd1, palette[2]);
    send_word(OP_FRAME, 6'd2, palette[3]);
    send_word(OP_REVERSE, 6'd0, palette[0]);
    send_word(OP_FRAME, 6'd0, palette[0]);
    send_word(OP_FRAME, 6'd0, palette[2]);
    send_word(OP_START_ON, 6'd32, palette[1]);
    send_word(OP_FRAME, 6'd0, palette[0]);
    send_word(OP_START_ON, 6'd21, palette[3]);
    send_word(OP_FRAME, 6'd42, palette[3]);

    // zero max_radius: growth finishes on its first step
    write_max_radius(0);
    send_word(OP_START_ON, 6'($urandom), rand_colour());
    send_frames(2);
    send_word(OP_START_OFF, 6'($urandom), rand_colour());
    send_frames(3);

    write_max_radius(64);
    hold_pending = 1'b1;
    run_sequences(45);

    write_max_radius(1);
    run_sequences(36);

    write_max_radius($urandom_range(2, 63));
    run_sequences(45);

    // radius saturation at the top: reload to 127 from below zero, then grow
    write_max_radius(127);
    send_word(OP_START_ON, 6'($urandom), rand_colour());
    send_word(OP_START_OFF, 6'($urandom), rand_colour());
    send_frames(1);
    send_word(OP_START_OFF, 6'($urandom), rand_colour());
    send_word(OP_REVERSE, 6'($urandom), rand_colour());
    send_frames(2);

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("[led_ring_slide_animation_top] OK");
    end else begin
      $display("[led_ring_slide_animation_top] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("[led_ring_slide_animation_top] ERROR");
    $finish;
  end

endmodule

>>> led_ring_slide_animation_top.f
rtl/core/lrsa_pkg.sv
rtl/core/lrsa_if.sv
rtl/core/lrsa_pixel_unit.sv
rtl/core/lrsa_ctrl.sv
rtl/core/led_ring_slide_animation_top.sv
dv/lrsa_frame_checker.sv
dv/tb_top.sv
